@@ design/sorted_list_table_defines.svh @@
// Assertion macros shared by the sorted list table RTL.
// Included by the top level; uses its clock and reset names.
`ifndef SORTED_LIST_TABLE_DEFINES_SVH
`define SORTED_LIST_TABLE_DEFINES_SVH

`define SLT_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("sorted_list_table: invariant violated");

`define SLT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted_list_table: sequence violated");

`endif

@@ design/slt_pkg.sv @@
// Package for the sorted list table: word types, status codes, cell control.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package slt_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int KEY_W        = 32;
   localparam int POS_W        = 6;
   localparam int CNT_W        = 7;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_EMPTY   = 2'd2;
   localparam logic [1:0] STATUS_MISSING = 2'd3;

   typedef logic signed [KEY_W-1:0] key_type;

   typedef struct packed {
      logic [1:0] req_type;
      key_type    value;
   } req_word_type;

   typedef struct packed {
      logic             ok;
      logic [1:0]       status;
      logic [POS_W-1:0] position;
      logic [CNT_W-1:0] count;
   } rsp_word_type;

   typedef struct packed {
      logic cmp_en;
      logic shift_ins;
      logic shift_rem;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_EXEC
   } state_type;

endpackage
`default_nettype wire

@@ design/slt_cell.sv @@
// One slot of the sorted table: holds an entry and its valid bit, compares
// it with the key and shifts with its neighbors. Depends on slt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module slt_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire slt_pkg::cell_ctl_type ctl,
   input  wire slt_pkg::key_type      key,
   input  wire slt_pkg::key_type      left_entry,
   input  wire logic                  left_valid,
   input  wire logic                  left_lt,
   input  wire slt_pkg::key_type      right_entry,
   input  wire logic                  right_valid,
   output slt_pkg::key_type           entry,
   output logic                       valid,
   output logic                       lt,
   output logic                       boundary,
   output logic                       hit
);

   slt_pkg::key_type entry_ff, entry_in;
   logic             valid_ff, valid_in;
   logic             lt_ff, lt_in;
   logic             eq_ff, eq_in;

   always_comb begin
      lt_in = lt_ff;
      eq_in = eq_ff;
      if (ctl.cmp_en) begin
         lt_in = valid_ff && (entry_ff < key);
         eq_in = valid_ff && (entry_ff == key);
      end
   end

   assign boundary = !lt_ff && left_lt;
   assign hit      = boundary && eq_ff;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctl.shift_ins && !lt_ff) begin
         if (boundary) begin
            entry_in = key;
            valid_in = 1'b1;
         end else begin
            entry_in = left_entry;
            valid_in = left_valid;
         end
      end else if (ctl.shift_rem && !lt_ff) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign entry = entry_ff;
   assign valid = valid_ff;
   assign lt    = lt_ff;

endmodule
`default_nettype wire

@@ design/sorted_list_table.sv @@
// Sorted list table: a request word is accepted in idle; the cells compare in the
// next cycle and shift in the exec state once the response register is free, and
// the response word is registered together with the shift. A new request is taken
// only after the compare and shift steps of the cell row, back in idle.
// Reset clears the entry count and every cell valid bit.
// Depends on slt_pkg, slt_cell and sorted_list_table_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_list_table_defines.svh"
module sorted_list_table #(
   parameter int CAPACITY = slt_pkg::CAPACITY_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire slt_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output slt_pkg::rsp_word_type      rsp_word
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW    = $clog2(CAPACITY + 1);

   slt_pkg::state_type    state_ff, state_in;
   slt_pkg::req_word_type req_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   slt_pkg::rsp_word_type rsp_ff, rsp_in;

   slt_pkg::cell_ctl_type ctl;
   slt_pkg::key_type      entry_vec [CAPACITY];
   logic [CAPACITY-1:0]   valid_vec, lt_vec, boundary_vec, hit_vec;

   logic             out_free, upd_go, is_ins, is_rem, full, empty, found;
   logic [IDX_W-1:0] pos_idx;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         slt_pkg::key_type l_entry, r_entry;
         logic             l_valid, l_lt, r_valid;
         if (g == 0) begin : g_first
            assign l_entry = req_ff.value;
            assign l_valid = 1'b0;
            assign l_lt    = 1'b1;
         end else begin : g_mid
            assign l_entry = entry_vec[g-1];
            assign l_valid = valid_vec[g-1];
            assign l_lt    = lt_vec[g-1];
         end
         if (g == CAPACITY - 1) begin : g_last
            assign r_entry = entry_vec[g];
            assign r_valid = 1'b0;
         end else begin : g_inner
            assign r_entry = entry_vec[g+1];
            assign r_valid = valid_vec[g+1];
         end
         slt_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .key         (req_ff.value),
            .left_entry  (l_entry),
            .left_valid  (l_valid),
            .left_lt     (l_lt),
            .right_entry (r_entry),
            .right_valid (r_valid),
            .entry       (entry_vec[g]),
            .valid       (valid_vec[g]),
            .lt          (lt_vec[g]),
            .boundary    (boundary_vec[g]),
            .hit         (hit_vec[g])
         );
      end
   endgenerate

   always_comb begin
      pos_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (boundary_vec[i]) begin
            pos_idx = pos_idx | IDX_W'(i);
         end
      end
   end

   assign found    = |hit_vec;
   assign full     = (count_ff == CW'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign is_ins   = (req_ff.req_type == slt_pkg::OP_INSERT);
   assign is_rem   = (req_ff.req_type == slt_pkg::OP_REMOVE);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         slt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = slt_pkg::ST_CMP;
            end
         end
         slt_pkg::ST_CMP: begin
            state_in = slt_pkg::ST_EXEC;
         end
         slt_pkg::ST_EXEC: begin
            if (out_free) begin
               state_in = slt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = slt_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == slt_pkg::ST_IDLE);
      upd_go        = (state_ff == slt_pkg::ST_EXEC) && out_free;
      ctl.cmp_en    = (state_ff == slt_pkg::ST_CMP);
      ctl.shift_ins = upd_go && is_ins && !full;
      ctl.shift_rem = upd_go && is_rem && found;
   end

   always_comb begin
      count_in        = count_ff;
      rsp_in.status   = slt_pkg::STATUS_OK;
      rsp_in.position = slt_pkg::POS_W'(pos_idx);
      if (is_ins) begin
         if (full) begin
            rsp_in.status   = slt_pkg::STATUS_FULL;
            rsp_in.position = '0;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end else if (empty) begin
         rsp_in.status   = slt_pkg::STATUS_EMPTY;
         rsp_in.position = '0;
      end else if (!found) begin
         rsp_in.status   = slt_pkg::STATUS_MISSING;
         rsp_in.position = '0;
      end else if (is_rem) begin
         count_in = count_ff - CW'(1);
      end
      rsp_in.ok    = (rsp_in.status == slt_pkg::STATUS_OK);
      rsp_in.count = slt_pkg::CNT_W'(count_in);

      rsp_valid_in = rsp_valid_ff;
      if (upd_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_word;
      end
      if (upd_go) begin
         rsp_ff <= rsp_in;
      end
      if (reset) begin
         state_ff     <= slt_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (upd_go) begin
            count_ff <= count_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `SLT_ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(CAPACITY))
   `SLT_ASSERT_ALWAYS(a_valid_matches_count, $countones(valid_vec) == int'(count_ff))
   `SLT_ASSERT_NEXT(a_accept_starts_compare, req_valid && req_ready,
                    state_ff == slt_pkg::ST_CMP)

endmodule
`default_nettype wire

@@ tb/sorted_list_table_tb.sv @@
// Self-checking testbench for sorted_list_table: a directed opening, then fill, drain
// and mixed phases of random requests, with bursty requests and a stalling response side.
// Depends on slt_pkg and the sorted_list_table RTL.
`timescale 1ns / 1ps
module sorted_list_table_tb;
   import slt_pkg::*;

   localparam int TABLE_DEPTH   = CAPACITY_DEF;
   localparam int RESET_CYCLES  = 9;
   localparam int RANDOM_ITEMS  = 1650;
   localparam int TAIL_CYCLES   = 12;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [1:0] OP_SEARCH     = 2'd2;
   localparam logic [1:0] OP_SEARCH_ALT = 2'd3;

   localparam key_type KEY_MIN = 32'sh8000_0000;
   localparam key_type KEY_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      req_word_type word;
      bit           hold_off;
   } pending_item_type;

   typedef enum {
      READY_ALWAYS,
      READY_COIN,
      READY_PERIODIC,
      READY_SPARSE
   } ready_mode_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   pending_item_type pending_items[$];
   rsp_word_type     pending_results[$];
   key_type          gen_keys[$];

   key_type stored_keys[TABLE_DEPTH];
   int      stored_count = 0;

   int burst_left = 1;
   int gap_left = 0;
   ready_mode_type ready_mode = READY_ALWAYS;
   int mode_left = 0;
   int periodic_phase = 0;

   int n_accepted = 0;
   int n_checked = 0;
   int n_errors = 0;
   int status_seen[4] = '{default: 0};
   int cycle_count = 0;

   sorted_list_table #(
      .CAPACITY(TABLE_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic rsp_word_type table_update(input req_word_type w);
      rsp_word_type r;
      logic [1:0]   st;
      key_type      key;
      int           idx;
      key = $signed(w.value);
      st = STATUS_OK;
      idx = 0;
      if (w.req_type == OP_INSERT) begin
         if (stored_count >= TABLE_DEPTH) begin
            st = STATUS_FULL;
         end else begin
            while (idx < stored_count && stored_keys[idx] < key) idx++;
            for (int j = stored_count; j > idx; j--) stored_keys[j] = stored_keys[j - 1];
            stored_keys[idx] = key;
            stored_count++;
         end
      end else if (stored_count == 0) begin
         st = STATUS_EMPTY;
      end else begin
         while (idx < stored_count && stored_keys[idx] != key) idx++;
         if (idx >= stored_count) begin
            st = STATUS_MISSING;
         end else if (w.req_type == OP_REMOVE) begin
            for (int j = idx; j + 1 < stored_count; j++) stored_keys[j] = stored_keys[j + 1];
            stored_count--;
         end
      end
      if (st != STATUS_OK) idx = 0;
      r.ok = (st == STATUS_OK);
      r.status = st;
      r.position = idx[POS_W-1:0];
      r.count = stored_count[CNT_W-1:0];
      return r;
   endfunction

   function automatic key_type pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return key_type'($signed($urandom_range(0, 16)) - 8);
      if (roll < 55) begin
         case ($urandom_range(0, 5))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return KEY_MIN + 1;
            3: return KEY_MAX - 1;
            4: return 0;
            default: return -1;
         endcase
      end
      return key_type'($urandom);
   endfunction

   function automatic key_type pick_lookup_key();
      if (gen_keys.size() > 0 && $urandom_range(0, 99) < 70)
         return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
      return pick_key();
   endfunction

   // Queues one request and keeps the generator's own view of the table contents
   // so that removes and searches can aim at keys that are present.
   task automatic add_item(input logic [1:0] op, input key_type key, input bit hold = 1'b0);
      pending_item_type it;
      it.word.req_type = op;
      it.word.value = key;
      it.hold_off = hold;
      pending_items.push_back(it);
      if (op == OP_INSERT) begin
         if (gen_keys.size() < TABLE_DEPTH) gen_keys.push_back(key);
      end else if (op == OP_REMOVE) begin
         foreach (gen_keys[i]) begin
            if (gen_keys[i] == key) begin
               gen_keys.delete(i);
               break;
            end
         end
      end
   endtask

   task automatic add_search(input key_type key, input bit hold = 1'b0);
      add_item($urandom_range(0, 1) ? OP_SEARCH : OP_SEARCH_ALT, key, hold);
   endtask

   task automatic add_weighted(input int insert_pct, input int remove_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) add_item(OP_INSERT, pick_key());
      else if (roll < insert_pct + remove_pct) add_item(OP_REMOVE, pick_lookup_key());
      else add_search(pick_lookup_key());
   endtask

   always @(posedge clock) begin : req_driver
      bit present;
      present = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
         req_word <= '0;
         stored_count = 0;
      end else begin
         if (req_valid && req_ready) begin
            pending_results.push_back(table_update(req_word));
            n_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_items.size() > 0 &&
                         !(pending_items[0].hold_off && pending_results.size() > 0)) begin
               req_word <= pending_items[0].word;
               pending_items.pop_front();
               present = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
            req_valid <= present;
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      rsp_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_checked++;
            status_seen[rsp_word.status]++;
            if (pending_results.size() == 0) begin
               n_errors++;
               if (n_errors <= REPORT_LIMIT)
                  $display("unexpected response word %0d: ok=%0d status=%0d position=%0d count=%0d",
                           n_checked, rsp_word.ok, rsp_word.status, rsp_word.position,
                           rsp_word.count);
            end else begin
               want = pending_results.pop_front();
               if (rsp_word.ok !== want.ok || rsp_word.status !== want.status ||
                   rsp_word.position !== want.position || rsp_word.count !== want.count) begin
                  n_errors++;
                  if (n_errors <= REPORT_LIMIT)
                     $display({"mismatch on response word %0d: expected ok=%0d status=%0d ",
                               "position=%0d count=%0d, got ok=%0d status=%0d position=%0d ",
                               "count=%0d"},
                              n_checked, want.ok, want.status, want.position, want.count,
                              rsp_word.ok, rsp_word.status, rsp_word.position, rsp_word.count);
               end
            end
         end
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 300);
         end else begin
            mode_left--;
         end
         periodic_phase = (periodic_phase + 1) % 4;
         case (ready_mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_COIN: rsp_ready <= 1'($urandom_range(0, 1));
            READY_PERIODIC: rsp_ready <= (periodic_phase == 0);
            default: rsp_ready <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, pending_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : stimulus
      int directed_items;
      int phase;
      int extra;

      add_search(0);
      add_item(OP_REMOVE, 5);
      add_item(OP_SEARCH_ALT, -1);
      add_item(OP_INSERT, 0);
      add_item(OP_INSERT, KEY_MAX);
      add_item(OP_INSERT, KEY_MIN);
      add_item(OP_INSERT, -1);
      add_item(OP_INSERT, 0);
      add_item(OP_SEARCH, 0);
      add_item(OP_SEARCH, KEY_MIN);
      add_item(OP_SEARCH, KEY_MAX);
      add_item(OP_SEARCH_ALT, -1);
      add_item(OP_SEARCH, 12345);
      add_item(OP_REMOVE, 7);
      add_item(OP_REMOVE, KEY_MAX);
      add_item(OP_REMOVE, KEY_MIN);
      add_item(OP_REMOVE, 0);
      add_item(OP_REMOVE, 0);
      add_item(OP_REMOVE, -1);
      add_item(OP_REMOVE, -1);
      add_item(OP_SEARCH_ALT, KEY_MAX);
      directed_items = pending_items.size();

      // Fill and drain phases drive the table to both ends; mixed phases sit in between.
      phase = 0;
      while (pending_items.size() < directed_items + RANDOM_ITEMS) begin
         case (phase % 4)
            0: begin
               while (gen_keys.size() < TABLE_DEPTH) add_weighted(75, 10);
               extra = $urandom_range(1, 4);
               repeat (extra) add_item(OP_INSERT, pick_key());
               add_item(OP_REMOVE, pick_lookup_key());
               add_search(pick_lookup_key());
            end
            2: begin
               add_search(pick_lookup_key(), 1'b1);
               while (gen_keys.size() > 0) add_weighted(10, 75);
               extra = $urandom_range(1, 3);
               repeat (extra) add_weighted(0, 50);
            end
            default: begin
               extra = $urandom_range(60, 140);
               repeat (extra) add_weighted(40, 30);
            end
         endcase
         phase++;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_items.size() > 0 || req_valid || pending_results.size() > 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      n_errors += pending_results.size();

      $display("Sent %0d requests in %0d cycles and checked %0d responses.",
               n_accepted, cycle_count, n_checked);
      $display("Responses by status: ok %0d, full %0d, empty %0d, not found %0d.",
               status_seen[STATUS_OK], status_seen[STATUS_FULL],
               status_seen[STATUS_EMPTY], status_seen[STATUS_MISSING]);
      if (n_errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d failures", n_errors);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
